/* rtl/apng_pkg.sv */
// Shared types, constants and helper functions for the APNG stream validator.
// Used by apng_ctrl, apng_dp and apng_stream_validator; depends on nothing.
package apng_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int OUT_DATA_W = 104;
	localparam int CAP_DEPTH  = 26;
	localparam int CAP_IDX_W  = $clog2(CAP_DEPTH);

	localparam logic [31:0] IHDR_LEN    = 32'd13;
	localparam logic [31:0] ACTL_LEN    = 32'd8;
	localparam logic [31:0] FCTL_LEN    = 32'd26;
	localparam logic [31:0] PALETTE_MAX = 32'd768;

	localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
	localparam logic [31:0] TAG_PLTE = 32'h504C_5445;
	localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
	localparam logic [31:0] TAG_IEND = 32'h4945_4E44;
	localparam logic [31:0] TAG_ACTL = 32'h6163_544C;
	localparam logic [31:0] TAG_FCTL = 32'h6663_544C;
	localparam logic [31:0] TAG_FDAT = 32'h6664_4154;

	localparam logic [7:0] SIG_BYTES [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
		8'h0D, 8'h0A, 8'h1A, 8'h0A};

	typedef enum logic [2:0] {
		PH_SIG, PH_LEN, PH_TYPE, PH_DATA, PH_CRC
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK, ST_FORMAT, ST_DIM, ST_LIMIT
	} status_t;

	typedef enum logic [1:0] {
		STG_BEFORE, STG_READING, STG_AFTER
	} stage_t;

	typedef enum logic [1:0] {
		KIND_NONE, KIND_IDAT, KIND_FDAT
	} kind_t;

	typedef enum logic [2:0] {
		CFG_FRAME_LIMIT, CFG_TOTAL_PIXEL_LIMIT, CFG_CHUNK_COUNT_LIMIT,
		CFG_DIMENSION_LIMIT, CFG_FRAME_PIXEL_LIMIT
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_RUN, S_CHK_MUL, S_CHK_EVAL, S_FIN_MUL1, S_FIN_MUL2, S_FIN_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic byte_en;
		logic last;
		logic chk_mul;
		logic chk_eval;
		logic fin_mul1;
		logic fin_mul2;
		logic fin_done;
	} cmd_t;

	typedef struct packed {
		logic chunk_end;
		logic out_free;
	} stat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ (32'hEDB8_8320 & {32{r[0]}});
		end
		return r;
	endfunction

	function automatic logic type_ok(input logic [31:0] t);
		logic ok;
		logic [7:0] v;
		ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			v = t[8*i +: 8];
			if (!((v >= 8'h41 && v <= 8'h5A) || (v >= 8'h61 && v <= 8'h7A))) begin
				ok = 1'b0;
			end
		end
		return ok && !t[13];
	endfunction

	// Residue mod 3 of a value up to 14.
	function automatic logic [1:0] mod3_small(input logic [3:0] v);
		logic [3:0] r;
		r = v;
		if (r >= 4'd9) r = r - 4'd9;
		if (r >= 4'd6) r = r - 4'd6;
		if (r >= 4'd3) r = r - 4'd3;
		return r[1:0];
	endfunction

endpackage

/* rtl/apng_ctrl.sv */
// Controller state machine: sequences byte intake, chunk checks and file finish.
// Depends on apng_pkg; drives apng_dp through cmd_t and reads stat_t.
module apng_ctrl import apng_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_last,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	ctrl_state_t state_q, state_n;
	logic        last_q;
	logic        byte_en;

	assign byte_en = in_valid && (state_q == S_RUN);

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_RUN: begin
				if (byte_en) begin
					if (stat.chunk_end) state_n = S_CHK_MUL;
					else if (in_last) state_n = S_FIN_MUL1;
				end
			end
			S_CHK_MUL:  state_n = S_CHK_EVAL;
			S_CHK_EVAL: state_n = last_q ? S_FIN_MUL1 : S_RUN;
			S_FIN_MUL1: state_n = S_FIN_MUL2;
			S_FIN_MUL2: state_n = S_FIN_DONE;
			S_FIN_DONE: begin
				if (stat.out_free) state_n = S_RUN;
			end
			default: state_n = S_RUN;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == S_RUN);
		cmd          = '0;
		cmd.byte_en  = byte_en;
		cmd.last     = last_q;
		cmd.chk_mul  = (state_q == S_CHK_MUL);
		cmd.chk_eval = (state_q == S_CHK_EVAL);
		cmd.fin_mul1 = (state_q == S_FIN_MUL1);
		cmd.fin_mul2 = (state_q == S_FIN_MUL2);
		cmd.fin_done = (state_q == S_FIN_DONE) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (byte_en) last_q <= in_last;
		end
	end

endmodule

/* rtl/apng_dp.sv */
// Datapath: byte framing, CRC, payload capture, chunk rules, finish checks,
// configuration registers and the result register. Depends on apng_pkg.
module apng_dp import apng_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic [7:0]            in_byte,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	// Configuration.
	logic [30:0] frame_limit_q;
	logic [47:0] total_pixel_limit_q;
	logic [19:0] chunk_count_limit_q;
	logic [15:0] dimension_limit_q;
	logic [31:0] frame_pixel_limit_q;

	// Per-file state.
	phase_t      phase_q;
	logic [31:0] fpos_q, len_q, type_q, crc_q, scrc_q;
	logic [7:0]  cap_q [CAP_DEPTH];
	status_t     err_q;
	logic [20:0] chunks_q;
	logic [15:0] cw_q, ch_q;
	logic [2:0]  ck_q;
	logic [30:0] fd_q, fcs_q;
	logic [31:0] pd_q, exp_q;
	logic        actl_q, plte_q, idat_q, idat_data_q, fdat_q, iend_q;
	logic        active_q, hasdata_q;
	stage_t      stage_q;
	kind_t       kind_q;
	logic [1:0]  lmod_q;
	logic [63:0] prod_q;
	logic [31:0] pix_q;
	logic [62:0] tot_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [31:0] c0, c4, c8, c12, c16, cw32, ch32;
	assign c0   = {cap_q[0], cap_q[1], cap_q[2], cap_q[3]};
	assign c4   = {cap_q[4], cap_q[5], cap_q[6], cap_q[7]};
	assign c8   = {cap_q[8], cap_q[9], cap_q[10], cap_q[11]};
	assign c12  = {cap_q[12], cap_q[13], cap_q[14], cap_q[15]};
	assign c16  = {cap_q[16], cap_q[17], cap_q[18], cap_q[19]};
	assign cw32 = {16'd0, cw_q};
	assign ch32 = {16'd0, ch_q};

	assign stat.chunk_end = (phase_q == PH_CRC) && (fpos_q == 32'd3) && (err_q == ST_OK);
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Chunk rule evaluation; all updates are committed only when the chunk passes.
	status_t     r;
	stage_t      stage_n;
	kind_t       kind_n;
	logic        active_n, hasdata_n, actl_n, plte_n, idat_n, idat_data_n, fdat_n, iend_n;
	logic [15:0] cw_n, ch_n;
	logic [2:0]  ck_n;
	logic [30:0] fd_n, fcs_n;
	logic [31:0] pd_n, exp_n;
	logic        critical, first, ihdr_ok, seq_ok;

	always_comb begin
		critical = (type_q == TAG_IHDR) || (type_q == TAG_PLTE) ||
			(type_q == TAG_IDAT) || (type_q == TAG_IEND);
		first    = (chunks_q == 21'd0);
		seq_ok   = !c0[31] && (c0 == exp_q) && (exp_q != 32'hFFFF_FFFF);
		case (cap_q[9])
			8'd0: ihdr_ok = (cap_q[8] == 8'd1) || (cap_q[8] == 8'd2) || (cap_q[8] == 8'd4) ||
				(cap_q[8] == 8'd8) || (cap_q[8] == 8'd16);
			8'd2, 8'd4, 8'd6: ihdr_ok = (cap_q[8] == 8'd8) || (cap_q[8] == 8'd16);
			8'd3: ihdr_ok = (cap_q[8] == 8'd1) || (cap_q[8] == 8'd2) || (cap_q[8] == 8'd4) ||
				(cap_q[8] == 8'd8);
			default: ihdr_ok = 1'b0;
		endcase
		ihdr_ok = ihdr_ok && (cap_q[10] == 8'd0) && (cap_q[11] == 8'd0) && (cap_q[12] <= 8'd1);

		r           = ST_OK;
		stage_n     = ((stage_q == STG_READING) && (type_q != TAG_IDAT)) ? STG_AFTER : stage_q;
		kind_n      = kind_q;
		active_n    = active_q;
		hasdata_n   = hasdata_q;
		actl_n      = actl_q;
		plte_n      = plte_q;
		idat_n      = idat_q;
		idat_data_n = idat_data_q;
		fdat_n      = fdat_q;
		iend_n      = iend_q;
		cw_n        = cw_q;
		ch_n        = ch_q;
		ck_n        = ck_q;
		fd_n        = fd_q;
		fcs_n       = fcs_q;
		pd_n        = pd_q;
		exp_n       = exp_q;

		if (!type_ok(type_q) || ((~crc_q) != scrc_q)) begin
			r = ST_FORMAT;
		end else if (!type_q[29] && !critical) begin
			r = ST_FORMAT;
		end else if (!first && (type_q == TAG_IHDR)) begin
			r = ST_FORMAT;
		end else if (first) begin
			if ((type_q != TAG_IHDR) || (len_q != IHDR_LEN) || !ihdr_ok) begin
				r = ST_FORMAT;
			end else if ((c0 == 32'd0) || (c4 == 32'd0) || (c0 > {16'd0, dimension_limit_q}) ||
					(c4 > {16'd0, dimension_limit_q})) begin
				r = ST_DIM;
			end else if (prod_q > {32'd0, frame_pixel_limit_q}) begin
				r = ST_LIMIT;
			end else begin
				cw_n = c0[15:0];
				ch_n = c4[15:0];
				ck_n = cap_q[9][2:0];
			end
		end else begin
			case (type_q)
				TAG_ACTL: begin
					if (actl_q || idat_q || (fcs_q != 31'd0) || (len_q != ACTL_LEN) ||
							(c0 == 32'd0) || c0[31]) begin
						r = ST_FORMAT;
					end else if ((frame_limit_q != 31'd0) && (c0[30:0] > frame_limit_q)) begin
						r = ST_LIMIT;
					end else begin
						fd_n   = c0[30:0];
						pd_n   = c4;
						actl_n = 1'b1;
					end
				end
				TAG_FCTL: begin
					if (!actl_q || (len_q != FCTL_LEN) || (fcs_q >= fd_q) ||
							(active_q && !hasdata_q) || !seq_ok) begin
						r = ST_FORMAT;
					end else if ((c4 == 32'd0) || (c8 == 32'd0) || (c12 > cw32) || (c16 > ch32) ||
							(c4 > cw32 - c12) || (c8 > ch32 - c16)) begin
						r = ST_DIM;
					end else if ((fcs_q == 31'd0) && !idat_q && ((c4 != cw32) || (c8 != ch32) ||
							(c12 != 32'd0) || (c16 != 32'd0))) begin
						r = ST_DIM;
					end else if ((cap_q[24] > 8'd2) || (cap_q[25] > 8'd1)) begin
						r = ST_FORMAT;
					end else begin
						active_n  = 1'b1;
						hasdata_n = 1'b0;
						kind_n    = idat_q ? KIND_FDAT : KIND_IDAT;
						fcs_n     = fcs_q + 31'd1;
						exp_n     = exp_q + 32'd1;
					end
				end
				TAG_PLTE: begin
					if (plte_q || idat_q || (len_q == 32'd0) || (len_q > PALETTE_MAX) ||
							(lmod_q != 2'd0) || (ck_q == 3'd0) || (ck_q == 3'd4)) begin
						r = ST_FORMAT;
					end else begin
						plte_n = 1'b1;
					end
				end
				TAG_IDAT: begin
					if (!actl_q || (stage_n == STG_AFTER) || fdat_q ||
							((ck_q == 3'd3) && !plte_q) || (active_q && (kind_q == KIND_FDAT))) begin
						r = ST_FORMAT;
					end else begin
						stage_n = STG_READING;
						idat_n  = 1'b1;
						if (len_q != 32'd0) begin
							idat_data_n = 1'b1;
							if (active_q && (kind_q == KIND_IDAT)) hasdata_n = 1'b1;
						end
					end
				end
				TAG_FDAT: begin
					if (!actl_q || (len_q <= 32'd4) || !idat_q || (stage_n != STG_AFTER) ||
							!active_q || (kind_q != KIND_FDAT) || !seq_ok) begin
						r = ST_FORMAT;
					end else begin
						hasdata_n = 1'b1;
						fdat_n    = 1'b1;
						exp_n     = exp_q + 32'd1;
					end
				end
				TAG_IEND: begin
					if ((len_q != 32'd0) || !cmd.last || !active_q || !hasdata_q) begin
						r = ST_FORMAT;
					end else begin
						iend_n = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Status at the end of the file.
	status_t fin_st;
	always_comb begin
		if (err_q != ST_OK) fin_st = err_q;
		else if ((phase_q != PH_LEN) || (fpos_q != 32'd0)) fin_st = ST_FORMAT;
		else if (!actl_q || !iend_q || !idat_q || !idat_data_q) fin_st = ST_FORMAT;
		else if (fcs_q != fd_q) fin_st = ST_FORMAT;
		else if ((ck_q == 3'd3) && !plte_q) fin_st = ST_FORMAT;
		else if (pix_q == 32'd0) fin_st = ST_DIM;
		else if ((total_pixel_limit_q != 48'd0) && (({16'd0, pix_q} > total_pixel_limit_q) ||
				(tot_q > {15'd0, total_pixel_limit_q}))) fin_st = ST_LIMIT;
		else fin_st = ST_OK;
	end

	logic [3:0] digit_sum;
	assign digit_sum = {2'd0, in_byte[1:0]} + {2'd0, in_byte[3:2]} + {2'd0, in_byte[5:4]} +
		{2'd0, in_byte[7:6]} + ((fpos_q == 32'd0) ? 4'd0 : {2'd0, lmod_q});

	// The capture bytes hold no reset; they are always written before use.
	always_ff @(posedge clk) begin
		if (cmd.byte_en && (err_q == ST_OK) && (phase_q == PH_DATA) &&
				(fpos_q < CAP_DEPTH)) begin
			cap_q[fpos_q[CAP_IDX_W-1:0]] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q       <= '0;
			total_pixel_limit_q <= '0;
			chunk_count_limit_q <= 20'd4096;
			dimension_limit_q   <= 16'd16384;
			frame_pixel_limit_q <= 32'd67108864;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FRAME_LIMIT:       frame_limit_q       <= cfg_wdata[30:0];
				CFG_TOTAL_PIXEL_LIMIT: total_pixel_limit_q <= cfg_wdata[47:0];
				CFG_CHUNK_COUNT_LIMIT: chunk_count_limit_q <= cfg_wdata[19:0];
				CFG_DIMENSION_LIMIT:   dimension_limit_q   <= cfg_wdata[15:0];
				CFG_FRAME_PIXEL_LIMIT: frame_pixel_limit_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (cmd.fin_done) begin
			out_valid_q <= 1'b1;
			out_data_q  <= '0;
			out_data_q[1:0] <= fin_st;
			if (fin_st == ST_OK) begin
				out_data_q[17:2]  <= cw_q;
				out_data_q[33:18] <= ch_q;
				out_data_q[64:34] <= fd_q;
				out_data_q[96:65] <= pd_q;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			fpos_q <= '0; len_q <= '0; type_q <= '0; crc_q <= '1; scrc_q <= '0;
			err_q <= ST_OK; chunks_q <= '0; cw_q <= '0; ch_q <= '0; ck_q <= '0;
			fd_q <= '0; fcs_q <= '0; pd_q <= '0; exp_q <= '0;
			actl_q <= 1'b0; plte_q <= 1'b0; idat_q <= 1'b0; idat_data_q <= 1'b0;
			fdat_q <= 1'b0; iend_q <= 1'b0; active_q <= 1'b0; hasdata_q <= 1'b0;
			stage_q <= STG_BEFORE; kind_q <= KIND_NONE; lmod_q <= '0;
			prod_q <= '0; pix_q <= '0; tot_q <= '0;
		end else if (cmd.fin_done) begin
			phase_q <= PH_SIG;
			fpos_q <= '0; len_q <= '0; type_q <= '0; crc_q <= '1; scrc_q <= '0;
			err_q <= ST_OK; chunks_q <= '0; cw_q <= '0; ch_q <= '0; ck_q <= '0;
			fd_q <= '0; fcs_q <= '0; pd_q <= '0; exp_q <= '0;
			actl_q <= 1'b0; plte_q <= 1'b0; idat_q <= 1'b0; idat_data_q <= 1'b0;
			fdat_q <= 1'b0; iend_q <= 1'b0; active_q <= 1'b0; hasdata_q <= 1'b0;
			stage_q <= STG_BEFORE; kind_q <= KIND_NONE; lmod_q <= '0;
		end else if (cmd.chk_mul) begin
			prod_q <= c0 * c4;
		end else if (cmd.chk_eval) begin
			chunks_q <= chunks_q + 21'd1;
			err_q    <= r;
			if (r == ST_OK) begin
				stage_q <= stage_n; kind_q <= kind_n; active_q <= active_n;
				hasdata_q <= hasdata_n; actl_q <= actl_n; plte_q <= plte_n;
				idat_q <= idat_n; idat_data_q <= idat_data_n; fdat_q <= fdat_n;
				iend_q <= iend_n; cw_q <= cw_n; ch_q <= ch_n; ck_q <= ck_n;
				fd_q <= fd_n; fcs_q <= fcs_n; pd_q <= pd_n; exp_q <= exp_n;
			end
		end else if (cmd.fin_mul1) begin
			pix_q <= cw_q * ch_q;
		end else if (cmd.fin_mul2) begin
			tot_q <= fd_q * pix_q;
		end else if (cmd.byte_en && (err_q == ST_OK)) begin
			case (phase_q)
				PH_SIG: begin
					if (in_byte != SIG_BYTES[fpos_q[2:0]]) begin
						err_q <= ST_FORMAT;
					end else if (fpos_q == 32'd7) begin
						phase_q <= PH_LEN;
						fpos_q  <= '0;
					end else begin
						fpos_q <= fpos_q + 32'd1;
					end
				end
				PH_LEN: begin
					if ((fpos_q == 32'd0) && (chunks_q >= {1'b0, chunk_count_limit_q})) begin
						err_q <= ST_LIMIT;
					end else begin
						len_q  <= {len_q[23:0], in_byte};
						lmod_q <= mod3_small(digit_sum);
						if (fpos_q == 32'd3) begin
							phase_q <= PH_TYPE;
							fpos_q  <= '0;
							crc_q   <= '1;
						end else begin
							fpos_q <= fpos_q + 32'd1;
						end
					end
				end
				PH_TYPE: begin
					type_q <= {type_q[23:0], in_byte};
					crc_q  <= crc_byte(crc_q, in_byte);
					if (fpos_q == 32'd3) begin
						fpos_q  <= '0;
						phase_q <= (len_q == 32'd0) ? PH_CRC : PH_DATA;
					end else begin
						fpos_q <= fpos_q + 32'd1;
					end
				end
				PH_DATA: begin
					crc_q <= crc_byte(crc_q, in_byte);
					if (fpos_q + 32'd1 == len_q) begin
						fpos_q  <= '0;
						phase_q <= PH_CRC;
					end else begin
						fpos_q <= fpos_q + 32'd1;
					end
				end
				PH_CRC: begin
					scrc_q <= {scrc_q[23:0], in_byte};
					if (fpos_q == 32'd3) begin
						fpos_q  <= '0;
						phase_q <= PH_LEN;
					end else begin
						fpos_q <= fpos_q + 32'd1;
					end
				end
				default: err_q <= ST_FORMAT;
			endcase
		end
	end

endmodule

/* rtl/apng_stream_validator.sv */
// APNG stream validator: one file byte per cycle while s_tready is high; a
// chunk's CRC byte stalls the input for the rule checks, the last byte for the
// finish multiplies and until the result register is free. One byte per cycle
// inside a chunk. arst_n clears all state but the capture bytes and loads the
// register defaults. Top level; depends on apng_pkg, apng_ctrl, apng_dp.
module apng_stream_validator import apng_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] file_byte
	input  logic                  s_tlast,   // last_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // status, image_width, image_height,
	                                         // frame_count, play_count, zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	apng_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	apng_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
